// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a implies b in the same cycle, reset disables
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// property a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/tds_pkg.sv =====
// ----------------------------------------------------------------------------
// tds_pkg
// shared constants and helpers for the tridiagonal solver
// ----------------------------------------------------------------------------
package tds_pkg;
  localparam int MAX_N_DEF     = 64;
  localparam int FRAC_BITS_DEF = 24;
  localparam int W             = 32;
  localparam int IDX_W         = 6;

  // saturate a 66 bit signed value to 32 bits
  function automatic logic signed [W-1:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[W-1:0];
  endfunction
endpackage

// ===== rtl/core/tds_if.sv =====
// ----------------------------------------------------------------------------
// tds_row_if / tds_sol_if
// valid/ready channels for input rows and solution beats
// ----------------------------------------------------------------------------
interface tds_row_if import tds_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [W-1:0] sub_diag;
  logic signed [W-1:0] main_diag;
  logic signed [W-1:0] super_diag;
  logic signed [W-1:0] rhs_value;
  logic last_row;
  modport source (output valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                  input ready);
  modport sink (input valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                output ready);
endinterface

interface tds_sol_if import tds_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [W-1:0] solution;
  logic [IDX_W-1:0] sol_index;
  logic last_out;
  logic singular;
  logic too_long;
  modport source (output valid, solution, sol_index, last_out, singular, too_long,
                  input ready);
  modport sink (input valid, solution, sol_index, last_out, singular, too_long,
                output ready);
endinterface

// ===== rtl/core/tds_div.sv =====
// ----------------------------------------------------------------------------
// tds_div
// radix-2 restoring divider: (p << FRAC_BITS) / q, truncated, saturated
// ----------------------------------------------------------------------------
module tds_div import tds_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] p,
  input  logic signed [W-1:0] q,
  output logic                done,
  output logic signed [W-1:0] quo
);
  localparam int NB = W + FRAC_BITS;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0] num;
  logic [W-1:0]  den;
  logic [W:0]    rem;
  logic [NB-1:0] qbits;
  logic          neg, zero, busy;
  logic [CW-1:0] cnt;
  logic [W:0]    trial;
  logic [W:0]    shifted;
  logic signed [65:0] sres;

  assign shifted = {rem[W-1:0], num[NB-1]};
  assign trial   = shifted - {1'b0, den};
  assign sres = neg ? -$signed({{(66-NB){1'b0}}, qbits}) : $signed({{(66-NB){1'b0}}, qbits});

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= CW'(NB);
      num   <= NB'(p[W-1] ? -{{(NB-W){p[W-1]}}, p} : {{(NB-W){1'b0}}, p}) << FRAC_BITS;
      den   <= q[W-1] ? W'(-q) : q;
      neg   <= p[W-1] ^ q[W-1];
      zero  <= (q == '0);
      rem   <= '0;
      qbits <= '0;
    end else if (busy) begin
      num <= num << 1;
      if (!trial[W]) begin
        rem   <= trial;
        qbits <= {qbits[NB-2:0], 1'b1};
      end else begin
        rem   <= shifted;
        qbits <= {qbits[NB-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quo = zero ? '0 : sat32(sres);
endmodule

// ===== rtl/core/tds_ctrl.sv =====
// ----------------------------------------------------------------------------
// tds_ctrl
// sequencer: forward elimination per row, back substitution, output beats
// ----------------------------------------------------------------------------
module tds_ctrl import tds_pkg::*; #(
  parameter int MAX_N     = MAX_N_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  tds_row_if.sink      row,
  tds_sol_if.source    sol
);
  localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CW = $clog2(MAX_N + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FDIV, S_FMUL1, S_FMUL2, S_FWR, S_BRD, S_BMUL, S_BDIV, S_BWR,
    S_ORD, S_OUT
  } state_t;

  state_t state;
  logic signed [W-1:0] d_mem [MAX_N];
  logic signed [W-1:0] r_mem [MAX_N];
  logic signed [W-1:0] u_mem [MAX_N];
  logic signed [W-1:0] x_mem [MAX_N];

  logic [CW-1:0] cnt;
  logic [AW-1:0] idx;
  logic sing, ovf, last_q;
  logic signed [W-1:0] a_q, c_q, f_q, b_q, m_q, d_new, prev_d, prev_r, prev_u, x_q;
  logic signed [W-1:0] mop_a, mop_b;
  logic signed [63:0] prod;
  logic signed [63:0] prod_q;
  logic div_start, div_done;
  logic signed [W-1:0] div_p, div_q, div_quo;

  tds_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .p(div_p), .q(div_q),
    .done(div_done), .quo(div_quo)
  );

  // shared multiplier, truncate toward zero
  assign prod = 64'(mop_a) * 64'(mop_b);
  always_comb begin
    logic signed [63:0] t;
    t = prod;
    if (t < 0) t = t + ((64'sd1 <<< FRAC_BITS) - 64'sd1);
    prod_q = t >>> FRAC_BITS;
  end

  assign row.ready = (state == S_IDLE) && !sol.valid;

  // sequencer
  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE; cnt <= '0; sing <= 1'b0; ovf <= 1'b0; sol.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (row.valid && row.ready) begin
          a_q <= row.sub_diag; c_q <= row.main_diag; b_q <= row.super_diag;
          f_q <= row.rhs_value; last_q <= row.last_row;
          if (cnt == CW'(MAX_N)) begin
            ovf <= 1'b1;
            state <= row.last_row ? S_BRD : S_IDLE;
            idx <= AW'(MAX_N - 1);
          end else if (cnt == '0) begin
            m_q <= '0; prev_u <= '0; prev_r <= '0;
            state <= S_FMUL1;
          end else begin
            prev_d <= d_mem[AW'(cnt - 1'b1)];
            prev_r <= r_mem[AW'(cnt - 1'b1)];
            prev_u <= u_mem[AW'(cnt - 1'b1)];
            // divider operands ready when start is seen
            div_p <= row.sub_diag;
            div_q <= d_mem[AW'(cnt - 1'b1)];
            state <= S_FDIV;
            div_start <= 1'b1;
          end
        end
        S_FDIV: begin
          if (div_done) begin m_q <= div_quo; state <= S_FMUL1; end
        end
        S_FMUL1: begin
          d_new <= sat32(66'(c_q) - 66'(prod_q)); state <= S_FMUL2;
        end
        S_FMUL2: begin
          d_mem[AW'(cnt)] <= d_new;
          r_mem[AW'(cnt)] <= sat32(66'(f_q) - 66'(prod_q));
          u_mem[AW'(cnt)] <= b_q;
          if (d_new == '0) sing <= 1'b1;
          state <= S_FWR;
        end
        S_FWR: begin
          cnt <= cnt + 1'b1;
          idx <= AW'(cnt);
          state <= last_q ? S_BRD : S_IDLE;
        end
        S_BRD: begin
          prev_d <= d_mem[idx]; prev_r <= r_mem[idx]; prev_u <= u_mem[idx];
          state <= S_BMUL;
        end
        S_BMUL: begin
          // last index has no x above it
          div_p <= (idx == AW'(cnt - 1'b1)) ? prev_r : sat32(66'(prev_r) - 66'(prod_q));
          div_q <= prev_d;
          div_start <= 1'b1;
          state <= S_BDIV;
        end
        S_BDIV: if (div_done) begin x_q <= div_quo; state <= S_BWR; end
        S_BWR: begin
          x_mem[idx] <= sing ? '0 : x_q;
          if (idx == '0) state <= S_ORD;
          else begin idx <= idx - 1'b1; state <= S_BRD; end
        end
        S_ORD: if (!sol.valid || sol.ready) begin
          sol.valid <= 1'b1;
          sol.solution <= x_mem[idx];
          sol.sol_index <= IDX_W'(idx);
          sol.last_out <= (idx == AW'(cnt - 1'b1));
          sol.singular <= sing; sol.too_long <= ovf;
          state <= S_OUT;
        end
        S_OUT: if (sol.ready) begin
          sol.valid <= 1'b0;
          if (sol.last_out) begin
            cnt <= '0; sing <= 1'b0; ovf <= 1'b0; state <= S_IDLE;
          end else begin idx <= idx + 1'b1; state <= S_ORD; end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    mop_a = m_q; mop_b = prev_u;
    case (state)
      S_FMUL2: mop_b = prev_r;
      S_BMUL: begin mop_a = prev_u; mop_b = x_q; end
      default: ;
    endcase
  end
endmodule

// ===== rtl/core/tridiagonal_solver.sv =====
// ----------------------------------------------------------------------------
// tridiagonal_solver
// Thomas-algorithm solver, Q8.24 fixed point, saturating
// ----------------------------------------------------------------------------
// Rows arrive one beat at a time; each takes one pass of the shared bit-serial
// divider plus the two multiplies before the next row is taken, and row 0 skips
// the divider. On the last row the block runs back substitution, one divider
// pass per row, then sends n solution beats from index 0 up. No row is taken
// until the last solution beat has gone. The divider sets the rate of the
// elimination and back substitution phases.
`include "assert_macros.svh"
module tridiagonal_solver import tds_pkg::*; #(
  parameter int MAX_N     = MAX_N_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tds_row_if.sink   row,
  tds_sol_if.source sol
);
  tds_ctrl #(.MAX_N(MAX_N), .FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk(clk), .rst(rst), .row(row), .sol(sol)
  );

  // no new row while results remain
  `ASSERT_IMPL(a_no_row_during_out, clk, rst, sol.valid, !row.ready)
  // singular systems give zero solutions
  `ASSERT_IMPL(a_sing_zero, clk, rst, sol.valid && sol.singular, sol.solution == '0)
  // a stalled beat holds
  `ASSERT_NEXT(a_hold, clk, rst, sol.valid && !sol.ready, sol.valid && $stable(sol.solution))
endmodule

// ===== bench/tridiagonal_solver_tb.sv =====
// ----------------------------------------------------------------------------
// tridiagonal_solver_tb
// Sends tridiagonal systems as row beats and compares every solution beat
// with a fixed-point Thomas-algorithm predictor kept in a scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tridiagonal_solver_tb;
  import tds_pkg::*;

  typedef struct packed {
    logic signed [31:0] solution;
    logic [5:0]         sol_index;
    logic               last_out;
    logic               singular;
    logic               too_long;
  } sol_beat_t;

  class thomas_board;
    logic signed [31:0] dstore[64];
    logic signed [31:0] rstore[64];
    logic signed [31:0] ustore[64];
    int rows;
    bit sing;
    bit ovf;
    sol_beat_t pending[$];
    int errors;

    function new();
      rows = 0; sing = 0; ovf = 0; errors = 0;
    endfunction

    function logic signed [31:0] sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    // product truncated toward zero
    function longint fmul(logic signed [31:0] p, logic signed [31:0] q);
      longint pr;
      pr = longint'(p) * longint'(q);
      return pr / (longint'(1) <<< 24);
    endfunction

    function logic signed [31:0] fdiv(logic signed [31:0] p, logic signed [31:0] q);
      if (q == 0) return 0;
      return sat((longint'(p) <<< 24) / longint'(q));
    endfunction

    // forward step on one row; solve when marked last
    function void note_row(logic signed [31:0] a, c, b, f, bit last);
      logic signed [31:0] d, r, m, num;
      logic signed [31:0] x[64];
      int n;
      if (rows < 64) begin
        d = c; r = f;
        if (rows > 0) begin
          m = fdiv(a, dstore[rows-1]);
          d = sat(longint'(c) - fmul(m, ustore[rows-1]));
          r = sat(longint'(f) - fmul(m, rstore[rows-1]));
        end
        if (d == 0) sing = 1;
        dstore[rows] = d; rstore[rows] = r; ustore[rows] = b;
        rows++;
      end else ovf = 1;
      if (!last) return;
      n = rows;
      if (n > 0) begin
        if (sing) for (int i = 0; i < n; i++) x[i] = 0;
        else begin
          x[n-1] = fdiv(rstore[n-1], dstore[n-1]);
          for (int j = n - 2; j >= 0; j--) begin
            num = sat(longint'(rstore[j]) - fmul(ustore[j], x[j+1]));
            x[j] = fdiv(num, dstore[j]);
          end
        end
        for (int i = 0; i < n; i++)
          pending.push_back('{x[i], 6'(i), i == n - 1, sing, ovf});
      end
      rows = 0; sing = 0; ovf = 0;
    endfunction

    function void check_beat(sol_beat_t got);
      sol_beat_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected solution beat %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  tds_row_if row_ch ();
  tds_sol_if sol_ch ();
  thomas_board board;
  bit calm;
  int idle_cycles;

  tridiagonal_solver u_dut (.clk(clk), .rst(rst), .row(row_ch.sink), .sol(sol_ch.source));

  // clock
  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver with random stall bursts
  initial begin
    int hold;
    sol_ch.ready = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && sol_ch.valid && sol_ch.ready)
        board.check_beat('{sol_ch.solution, sol_ch.sol_index, sol_ch.last_out,
                           sol_ch.singular, sol_ch.too_long});
      if (hold > 0) begin
        hold--;
        sol_ch.ready <= 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 4);
        sol_ch.ready <= 0;
      end else sol_ch.ready <= 1;
    end
  end

  // watchdog on beats accepted
  always @(posedge clk) begin
    if (rst || (row_ch.valid && row_ch.ready) || (sol_ch.valid && sol_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[tridiagonal_solver] ERROR");
      $finish;
    end
  end

  // valid stays up after a beat unless an idle burst follows
  task automatic send_row(logic [31:0] a, c, b, f, bit last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      row_ch.valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    row_ch.valid <= 1;
    row_ch.sub_diag <= a; row_ch.main_diag <= c;
    row_ch.super_diag <= b; row_ch.rhs_value <= f; row_ch.last_row <= last;
    do @(posedge clk); while (!row_ch.ready);
    board.note_row(a, c, b, f, last);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return $signed($urandom_range(0, 32'h3ffffff)) - 32'sh1ffffff;
    endcase
  endfunction

  // well-formed, diagonally dominant system with random content
  task automatic send_system(int n);
    logic [31:0] a, b, c;
    for (int i = 0; i < n; i++) begin
      a = $signed($urandom_range(0, 32'h1ffffff)) - 32'sh0ffffff;
      b = $signed($urandom_range(0, 32'h1ffffff)) - 32'sh0ffffff;
      c = ($urandom_range(0, 1) ? 32'sh3000000 : -32'sh3000000)
          + $signed($urandom_range(0, 32'hffffff));
      send_row(a, c, b, rnd_val(), i == n - 1);
    end
  endtask

  initial begin
    int sent;
    board = new();
    calm = 0;
    rst = 1;
    row_ch.valid = 0; row_ch.sub_diag = 0; row_ch.main_diag = 0;
    row_ch.super_diag = 0; row_ch.rhs_value = 0; row_ch.last_row = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: single row, extremes, zero pivot, zero later pivot
    send_row(32'h80000000, 32'h01000000, 32'h7fffffff, 32'h7fffffff, 1);
    send_row(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    send_row(32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'h00000001, 1);
    send_row(0, 0, 32'h01000000, 32'h01000000, 0);
    send_row(32'h01000000, 32'h02000000, 0, 32'h01000000, 1);
    send_row(0, 32'h01000000, 32'h01000000, 32'h02000000, 0);
    send_row(32'h01000000, 32'h01000000, 0, 32'hffffffff, 1);
    send_row(32'h00000001, 32'h7fffffff, 32'h80000000, 32'h80000000, 1);
    // too many rows, last two dropped
    for (int i = 0; i < 66; i++)
      send_row($urandom() & 32'h00ffffff, 32'h04000000, $urandom() & 32'h00ffffff,
               $urandom(), i == 65);
    sent = 0;
    while (sent < 236) begin
      int n;
      if ($urandom_range(0, 9) == 0) begin
        send_row(rnd_val(), rnd_val(), rnd_val(), rnd_val(), $urandom_range(0, 1));
        sent++;
      end else begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 6);
        if (sent > 190) calm = 1;
        send_system(n);
        sent += n;
      end
    end
    send_row(0, 32'h01000000, 0, 32'h01000000, 1);
    row_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("[tridiagonal_solver] OK");
    else
      $display("[tridiagonal_solver] ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tds_pkg.sv
rtl/core/tds_if.sv
rtl/core/tds_div.sv
rtl/core/tds_ctrl.sv
rtl/core/tridiagonal_solver.sv
bench/tridiagonal_solver_tb.sv
